### hw/rtl/rqs_pkg.sv
// Shared types and constants for the request queue scheduler.
// Entry layout, controller command/status bundles, state and code names.
// No dependencies.
package rqs_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // register map (index = word address)
   localparam logic REG_POLICY   = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   localparam logic       POLICY_RESET   = 1'b0;
   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic POLICY_FIFO     = 1'b0;
   localparam logic POLICY_SMALLEST = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0] handle;
      logic [31:0] name_tag;
      logic [31:0] file_size;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;       // latch the request word, do the push
      logic scan_run;     // read entries in order, keep the pick
      logic shift_start;  // last compare seen, aim at the entry behind the pick
      logic shift_run;    // move entries down one slot
      logic finish;       // drop the popped entry from the count
      logic load_rsp;     // move the result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_pop;
      logic empty;
      logic issue_done;
      logic rd_valid;
      logic last_cmp;
      logic rsp_free;
   } ctrl_stat_type;

endpackage

### hw/rtl/rqs_ctrl.sv
// Sequencer for the request queue scheduler: accept, scan, close up, respond.
// Depends on rqs_pkg.
module rqs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rqs_pkg::ctrl_stat_type stat,
   output rqs_pkg::ctrl_cmd_type  cmd
);

   rqs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rqs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rqs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (stat.is_pop && !stat.empty) ? rqs_pkg::ST_SCAN
                                                         : rqs_pkg::ST_DONE;
            end
         end
         rqs_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.last_cmp) begin
               cmd.shift_start = 1'b1;
               state_in        = rqs_pkg::ST_SHIFT;
            end
         end
         rqs_pkg::ST_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (stat.issue_done && !stat.rd_valid) begin
               cmd.finish = 1'b1;
               state_in   = rqs_pkg::ST_DONE;
            end
         end
         rqs_pkg::ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = rqs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rqs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/rqs_datapath.sv
// Datapath for the request queue scheduler: entry store, count, scan and
// close-up address logic, output register. Depends on rqs_pkg.
module rqs_datapath #(
   parameter int DEPTH = rqs_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rqs_pkg::ctrl_cmd_type  cmd,
   output rqs_pkg::ctrl_stat_type stat,
   input  logic                   cfg_policy,
   input  logic [4:0]             cfg_capacity,
   input  logic                   req_command,
   input  logic [15:0]            req_request_handle,
   input  logic [31:0]            req_name_tag,
   input  logic [31:0]            req_file_size,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [15:0]            rsp_out_handle,
   output logic [31:0]            rsp_out_name_tag,
   output logic [31:0]            rsp_out_file_size,
   output logic [4:0]             rsp_occupancy
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rqs_pkg::entry_type store_ff [DEPTH];
   rqs_pkg::entry_type rd_data_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               issue_done_ff, issue_done_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [AW-1:0]      pick_ff, pick_in;
   logic [AW-1:0]      scan_last_ff, scan_last_in;
   rqs_pkg::entry_type best_ff, best_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rqs_pkg::entry_type rsp_entry_ff, rsp_entry_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_occ_ff, rsp_occ_in;

   logic               full, empty, is_pop, issue, take, last_cmp;
   logic [CW-1:0]      count_m1, last_src;
   logic [AW-1:0]      pick_nx;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   rqs_pkg::entry_type wr_data;

   always_comb begin
      is_pop   = (req_command == rqs_pkg::CMD_POP);
      empty    = (count_ff == '0);
      full     = (32'(count_ff) >= 32'(cfg_capacity)) || (32'(count_ff) >= 32'(DEPTH));
      count_m1 = count_ff - CW'(1);
      last_src = cmd.shift_run ? count_m1 : CW'(scan_last_ff);
      issue    = (cmd.scan_run || cmd.shift_run) && !issue_done_ff;
      take     = cmd.scan_run && rd_valid_ff &&
                 ((rd_idx_ff == '0) || (rd_data_ff.file_size < best_ff.file_size));
      pick_nx  = take ? rd_idx_ff : pick_ff;
      last_cmp = cmd.scan_run && rd_valid_ff && (rd_idx_ff == scan_last_ff);

      count_in      = count_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      rd_valid_in   = issue;
      rd_idx_in     = idx_ff;
      pick_in       = pick_nx;
      scan_last_in  = scan_last_ff;
      best_in       = take ? rd_data_ff : best_ff;
      status_in     = status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      wr_en   = 1'b0;
      wr_addr = rd_idx_ff - AW'(1);
      wr_data = rd_data_ff;

      // advance the read pointer; stop after the last source entry
      if (issue) begin
         idx_in        = idx_ff + AW'(1);
         issue_done_in = (CW'(idx_ff) == last_src);
      end

      // close up: start reading just behind the pick
      if (cmd.shift_start) begin
         idx_in        = pick_nx + AW'(1);
         issue_done_in = (CW'(pick_nx) == count_m1);
      end

      // each word read during close-up lands one slot lower
      if (cmd.shift_run && rd_valid_ff) begin
         wr_en = 1'b1;
      end

      if (cmd.accept) begin
         best_in       = '0;
         idx_in        = '0;
         issue_done_in = 1'b0;
         scan_last_in  = (cfg_policy == rqs_pkg::POLICY_SMALLEST) ? AW'(count_m1) : '0;
         status_in     = rqs_pkg::STATUS_OK;
         if (is_pop) begin
            if (empty) begin
               status_in = rqs_pkg::STATUS_EMPTY;
            end
         end else if (full) begin
            status_in = rqs_pkg::STATUS_FULL;
         end else begin
            wr_en    = 1'b1;
            wr_addr  = AW'(count_ff);
            wr_data  = '{handle: req_request_handle, name_tag: req_name_tag,
                         file_size: req_file_size};
            count_in = count_ff + CW'(1);
         end
      end

      if (cmd.finish) begin
         count_in = count_m1;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = best_ff;
         rsp_status_in = status_ff;
         rsp_occ_in    = 5'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= store_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         issue_done_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         issue_done_ff <= issue_done_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      pick_ff       <= pick_in;
      scan_last_ff  <= scan_last_in;
      best_ff       <= best_in;
      status_ff     <= status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      stat.is_pop     = is_pop;
      stat.empty      = empty;
      stat.issue_done = issue_done_ff;
      stat.rd_valid   = rd_valid_ff;
      stat.last_cmp   = last_cmp;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_handle    = rsp_entry_ff.handle;
   assign rsp_out_name_tag  = rsp_entry_ff.name_tag;
   assign rsp_out_file_size = rsp_entry_ff.file_size;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule

### hw/rtl/request_queue_scheduler.sv
// Request queue scheduler: bounded buffer of (handle, tag, size) in arrival order.
// Push, rejected push, empty pop: accept, then done state, then the output register loads.
// A pop with entries held scans the single read port (FIFO: oldest entry only; smallest-first:
// every entry), then walks it again to close up behind the pick. The next word is taken in the
// cycle after the result loads; a result still waiting for rsp_ready holds that load. Reset:
// count to zero, policy FIFO, capacity 16, store not cleared. Uses rqs_ctrl, rqs_datapath.
module request_queue_scheduler #(
   parameter int DEPTH = rqs_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_request_handle,
   input  logic [31:0] req_name_tag,
   input  logic [31:0] req_file_size,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_handle,
   output logic [31:0] rsp_out_name_tag,
   output logic [31:0] rsp_out_file_size,
   output logic [4:0]  rsp_occupancy,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Control registers. The register index is the word address bit; the
   // low byte-offset bits are ignored.
   logic       policy_ff, policy_in;
   logic [4:0] capacity_ff, capacity_in;
   logic       csr_wr;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      policy_in   = policy_ff;
      capacity_in = capacity_ff;
      csr_prdata  = '0;
      case (reg_sel)
         rqs_pkg::REG_POLICY: begin
            csr_prdata = {31'd0, policy_ff};
            if (csr_wr) begin
               policy_in = csr_pwdata[0];
            end
         end
         rqs_pkg::REG_CAPACITY: begin
            csr_prdata = {27'd0, capacity_ff};
            if (csr_wr) begin
               capacity_in = csr_pwdata[4:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= rqs_pkg::POLICY_RESET;
         capacity_ff <= rqs_pkg::CAPACITY_RESET;
      end else begin
         policy_ff   <= policy_in;
         capacity_ff <= capacity_in;
      end
   end

   // Sequencer and datapath talk only through these two bundles.
   rqs_pkg::ctrl_cmd_type  cmd;
   rqs_pkg::ctrl_stat_type stat;

   rqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The result sits in an output register, so a new request word is taken
   // while the previous result still waits for rsp_ready.
   rqs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .cfg_policy         (policy_ff),
      .cfg_capacity       (capacity_ff),
      .req_command        (req_command),
      .req_request_handle (req_request_handle),
      .req_name_tag       (req_name_tag),
      .req_file_size      (req_file_size),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_name_tag   (rsp_out_name_tag),
      .rsp_out_file_size  (rsp_out_file_size),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule

### sim/testbench.sv
// Testbench for request_queue_scheduler: a directed table of request words, then random
// traffic under several register settings, checked against an in-bench model of the buffer.
// Depends on rqs_pkg and the request_queue_scheduler RTL.
module testbench;

   localparam int SLOTS = rqs_pkg::DEPTH_DEFAULT;

   // one result word as the block reports it
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] handle;
      logic [31:0] name_tag;
      logic [31:0] file_size;
      logic [4:0]  occupancy;
   } sched_result_type;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   // one row of stimulus: a request word, or a register write between phases
   typedef struct {
      row_kind_type     kind;
      logic             command;
      logic [15:0]      handle;
      logic [31:0]      name_tag;
      logic [31:0]      file_size;
      logic             reg_index;
      logic [4:0]       reg_value;
      bit               has_typed;
      sched_result_type typed_result;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = rqs_pkg::CMD_PUSH;
   logic [15:0] req_request_handle = '0;
   logic [31:0] req_name_tag = '0;
   logic [31:0] req_file_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_handle;
   logic [31:0] rsp_out_name_tag;
   logic [31:0] rsp_out_file_size;
   logic [4:0]  rsp_occupancy;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow copy of the buffer: slot 0 is the oldest entry
   rqs_pkg::entry_type shadow_slots [SLOTS];
   int unsigned        shadow_held = 0;
   logic               shadow_policy = rqs_pkg::POLICY_RESET;
   logic [4:0]         shadow_cap = rqs_pkg::CAPACITY_RESET;

   sched_result_type due_results [$];
   stim_row_type     directed_rows [$];
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   request_queue_scheduler #(.DEPTH(SLOTS)) u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run (long gaps, long stalls, full scans).
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Work out the result of one accepted word and advance the shadow buffer.
   function automatic sched_result_type buffer_step(logic command, logic [15:0] handle,
                                                    logic [31:0] name_tag,
                                                    logic [31:0] file_size);
      sched_result_type res;
      int unsigned      limit;
      int unsigned      pick;
      int unsigned      i;
      res = '0;
      res.status = rqs_pkg::STATUS_OK;
      // capacity above the store depth is clamped to the depth
      limit = (shadow_cap > SLOTS) ? SLOTS : shadow_cap;
      if (command == rqs_pkg::CMD_PUSH) begin
         if (shadow_held >= limit) begin
            res.status = rqs_pkg::STATUS_FULL;
         end else begin
            shadow_slots[shadow_held] = '{handle: handle, name_tag: name_tag,
                                          file_size: file_size};
            shadow_held++;
         end
      end else if (shadow_held == 0) begin
         res.status = rqs_pkg::STATUS_EMPTY;
      end else begin
         pick = 0;
         // smallest size wins; strict compare keeps the earliest arrival on a tie
         if (shadow_policy == rqs_pkg::POLICY_SMALLEST) begin
            for (i = 1; i < shadow_held; i++) begin
               if (shadow_slots[i].file_size < shadow_slots[pick].file_size) pick = i;
            end
         end
         res.handle    = shadow_slots[pick].handle;
         res.name_tag  = shadow_slots[pick].name_tag;
         res.file_size = shadow_slots[pick].file_size;
         // close up behind the removed entry
         for (i = pick; i + 1 < shadow_held; i++) shadow_slots[i] = shadow_slots[i + 1];
         shadow_held--;
      end
      res.occupancy = shadow_held[4:0];
      return res;
   endfunction

   // Offer one word; hold valid and payload until the block takes it.
   task automatic send_word(input stim_row_type row);
      sched_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= row.command;
      req_request_handle <= row.handle;
      req_name_tag       <= row.name_tag;
      req_file_size      <= row.file_size;
      do @(posedge clock); while (!req_ready);
      // the model still advances on typed rows; only the expectation is taken from the table
      predicted = buffer_step(row.command, row.handle, row.name_tag, row.file_size);
      due_results.push_back(row.has_typed ? row.typed_result : predicted);
      @(negedge clock);
   endtask

   // Drain the block, then write one register through a setup and an access cycle.
   task automatic write_reg(input logic index, input logic [4:0] value);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {27'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == rqs_pkg::REG_POLICY) shadow_policy = value[0];
      else shadow_cap = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Table builders for the directed part.
   function automatic void dir_word(logic command, logic [15:0] handle, logic [31:0] name_tag,
                                    logic [31:0] file_size);
      stim_row_type row;
      row = '{kind: ROW_WORD, command: command, handle: handle, name_tag: name_tag,
              file_size: file_size, reg_index: rqs_pkg::REG_POLICY, reg_value: '0,
              has_typed: 1'b0, typed_result: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void dir_checked(logic command, logic [15:0] handle,
                                       logic [31:0] name_tag, logic [31:0] file_size,
                                       sched_result_type typed_result);
      stim_row_type row;
      row = '{kind: ROW_WORD, command: command, handle: handle, name_tag: name_tag,
              file_size: file_size, reg_index: rqs_pkg::REG_POLICY, reg_value: '0,
              has_typed: 1'b1, typed_result: typed_result};
      directed_rows.push_back(row);
   endfunction

   function automatic void dir_reg(logic index, logic [4:0] value);
      stim_row_type row;
      row = '{kind: ROW_REG, command: rqs_pkg::CMD_PUSH, handle: '0, name_tag: '0,
              file_size: '0, reg_index: index, reg_value: value, has_typed: 1'b0,
              typed_result: '0};
      directed_rows.push_back(row);
   endfunction

   // Receiver: drop ready at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("result word with no expectation waiting");
            mismatch_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_out_handle !== want.handle) begin
               $error("out_handle: expected %h, got %h", want.handle, rsp_out_handle);
               mismatch_count++;
            end
            if (rsp_out_name_tag !== want.name_tag) begin
               $error("out_name_tag: expected %h, got %h", want.name_tag, rsp_out_name_tag);
               mismatch_count++;
            end
            if (rsp_out_file_size !== want.file_size) begin
               $error("out_file_size: expected %h, got %h", want.file_size,
                      rsp_out_file_size);
               mismatch_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int unsigned  phase;
      int unsigned  seg;
      int unsigned  n;
      int unsigned  roll;
      logic [4:0]   cap;

      // Reset once, then release at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Typed rows: empty pop after reset, full-scale and zero entries,
      // rejected pushes. The rest is left to the model.
      dir_checked(rqs_pkg::CMD_POP, 16'h0000, 32'h0, 32'h0,
                  '{rqs_pkg::STATUS_EMPTY, 16'h0, 32'h0, 32'h0, 5'd0});
      dir_checked(rqs_pkg::CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  '{rqs_pkg::STATUS_OK, 16'h0, 32'h0, 32'h0, 5'd1});
      dir_checked(rqs_pkg::CMD_PUSH, 16'h0000, 32'h0, 32'h0,
                  '{rqs_pkg::STATUS_OK, 16'h0, 32'h0, 32'h0, 5'd2});
      // push fields on a pop are junk and must be ignored
      dir_checked(rqs_pkg::CMD_POP, 16'h1234, 32'hDEAD_BEEF, 32'h0000_0001,
                  '{rqs_pkg::STATUS_OK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1});
      dir_checked(rqs_pkg::CMD_POP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  '{rqs_pkg::STATUS_OK, 16'h0, 32'h0, 32'h0, 5'd0});
      // smallest-first, with a tie between two equal sizes
      dir_reg(rqs_pkg::REG_POLICY, {4'd0, rqs_pkg::POLICY_SMALLEST});
      dir_word(rqs_pkg::CMD_PUSH, 16'h0101, 32'hA000_0001, 32'd500);
      dir_word(rqs_pkg::CMD_PUSH, 16'h0202, 32'hA000_0002, 32'd100);
      dir_word(rqs_pkg::CMD_PUSH, 16'h0303, 32'hA000_0003, 32'd100);
      dir_word(rqs_pkg::CMD_PUSH, 16'h0404, 32'hA000_0004, 32'hFFFF_FFFF);
      dir_word(rqs_pkg::CMD_PUSH, 16'h0505, 32'hA000_0005, 32'd0);
      dir_word(rqs_pkg::CMD_POP, 16'h0, 32'h0, 32'h0);
      dir_word(rqs_pkg::CMD_POP, 16'h0, 32'h0, 32'h0);
      dir_word(rqs_pkg::CMD_POP, 16'h0, 32'h0, 32'h0);
      // capacity lowered below occupancy: pushes bounce, pops still work
      dir_reg(rqs_pkg::REG_CAPACITY, 5'd1);
      dir_checked(rqs_pkg::CMD_PUSH, 16'h0606, 32'hA000_0006, 32'd1,
                  '{rqs_pkg::STATUS_FULL, 16'h0, 32'h0, 32'h0, 5'd2});
      dir_word(rqs_pkg::CMD_POP, 16'h0, 32'h0, 32'h0);
      dir_checked(rqs_pkg::CMD_PUSH, 16'h0707, 32'hA000_0007, 32'd2,
                  '{rqs_pkg::STATUS_FULL, 16'h0, 32'h0, 32'h0, 5'd1});
      dir_word(rqs_pkg::CMD_POP, 16'h0, 32'h0, 32'h0);
      // capacity zero rejects every push
      dir_reg(rqs_pkg::REG_CAPACITY, 5'd0);
      dir_checked(rqs_pkg::CMD_PUSH, 16'h0808, 32'hA000_0008, 32'd3,
                  '{rqs_pkg::STATUS_FULL, 16'h0, 32'h0, 32'h0, 5'd0});
      dir_checked(rqs_pkg::CMD_POP, 16'h0, 32'h0, 32'h0,
                  '{rqs_pkg::STATUS_EMPTY, 16'h0, 32'h0, 32'h0, 5'd0});
      // capacity above depth, back to FIFO order
      dir_reg(rqs_pkg::REG_CAPACITY, 5'd31);
      dir_reg(rqs_pkg::REG_POLICY, {4'd0, rqs_pkg::POLICY_FIFO});
      dir_word(rqs_pkg::CMD_PUSH, 16'h0909, 32'hA000_0009, 32'd77);
      dir_word(rqs_pkg::CMD_POP, 16'h0, 32'h0, 32'h0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG)
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         else
            send_word(directed_rows[i]);
      end

      // Random part: three idling phases, eight register settings each. Every setting
      // runs a push-heavy stretch that tends to fill the buffer, then a pop-heavy one.
      row = directed_rows[0];
      row.kind      = ROW_WORD;
      row.has_typed = 1'b0;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 80;
            end
            1: begin
               send_idle_pct = 80;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (seg = 0; seg < 8; seg++) begin
            case (seg)
               0: cap = 5'd31;
               1: cap = 5'd16;
               2: cap = 5'd1;
               3: cap = 5'd0;
               default: cap = 5'($urandom_range(0, 31));
            endcase
            write_reg(rqs_pkg::REG_POLICY,
                      ((seg + phase) % 2 == 0) ? {4'd0, rqs_pkg::POLICY_FIFO}
                                               : {4'd0, rqs_pkg::POLICY_SMALLEST});
            write_reg(rqs_pkg::REG_CAPACITY, cap);
            for (n = 0; n < 42; n++) begin
               row.command  = ($urandom_range(0, 99) < ((n < 24) ? 85 : 25))
                              ? rqs_pkg::CMD_PUSH : rqs_pkg::CMD_POP;
               row.handle   = 16'($urandom);
               row.name_tag = $urandom;
               // favor a narrow size range so that ties come up often
               roll = $urandom_range(0, 9);
               case (roll)
                  0: row.file_size = 32'h0;
                  1: row.file_size = 32'hFFFF_FFFF;
                  2, 3, 4, 5: row.file_size = $urandom_range(0, 15);
                  default: row.file_size = $urandom;
               endcase
               send_word(row);
            end
         end
      end

      // Drop valid, wait out every owed result, then let a few more cycles pass so a
      // stray extra word would still be caught.
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### request_queue_scheduler.f
hw/rtl/rqs_pkg.sv
hw/rtl/rqs_ctrl.sv
hw/rtl/rqs_datapath.sv
hw/rtl/request_queue_scheduler.sv
sim/testbench.sv
